// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion violated");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion violated");

`endif

// ===== design/gpng_pkg.sv =====
// Package with the widths, constants and types of the polar Gaussian generator.
`timescale 1ns / 1ps
package gpng_pkg;

   // Input uniform width and the fraction bits of a Q1.F uniform.
   localparam int UW     = 16;
   localparam int FW     = UW - 1;
   localparam int AM_W   = FW;
   localparam int SQ_W   = 2 * UW;
   localparam int RSUM_W = 2 * UW + 1;
   localparam int R_W    = 2 * FW;
   localparam logic [RSUM_W-1:0] R_ONE = RSUM_W'(1) << R_W;

   // Logarithm datapath.
   localparam int XW          = 32;
   localparam int LOG_ROUNDS  = 32;
   localparam int FRAC_W      = LOG_ROUNDS;
   localparam int INT_W       = 6;
   localparam int L_W         = INT_W + FRAC_W;
   localparam int TP_W        = L_W - 8 + 32;
   localparam int T_W         = TP_W - 31;
   localparam logic [31:0] LN2_Q32 = 32'd2977044471;
   localparam int T_SHIFT     = 24;
   localparam int NORM_STAGES = 2;

   // Square root and divider units.
   localparam int SQ_IN_W     = 64;
   localparam int SQ_OUT_W    = 32;
   localparam int SQ_REM_W    = 34;
   localparam int SQRT_STAGES = 32;
   localparam int DIV_W       = 64;
   localparam int DQ_W        = 32;
   localparam int DIV_STAGES  = 32;
   localparam int Q_SHIFT     = 62 - 2 * FW;
   localparam int C_SHIFT     = 61 - FW;

   // Back pipeline alignment.
   localparam int LOG_LAT = NORM_STAGES + LOG_ROUNDS + 2;
   localparam int C_DLY   = LOG_LAT - DIV_STAGES;
   localparam int M_LAT   = LOG_LAT + SQRT_STAGES + 2;

   // Scaling and output.
   localparam int CFG_W  = 16;
   localparam int P_W    = 2 * DQ_W - 30;
   localparam int MP_W   = P_W + CFG_W;
   localparam int SUM_W  = P_W + 3;
   localparam int OUT_W  = 32;
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sd2147483647);
   localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sd2147483648);

   // Request queue.
   localparam int Q_DEPTH = 8;
   localparam int Q_AW    = 3;
   localparam int Q_CW    = 4;
   localparam int CR_W    = Q_CW + 1;

   // Configuration registers.
   localparam int CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MEAN    = 2'd0,
      CSR_STD_DEV = 2'd1
   } csr_index_type;
   localparam logic [CFG_W-1:0] STD_RESET = 16'd256;

   typedef struct packed {
      logic            neg1;
      logic            neg2;
      logic [AM_W-1:0] mag1;
      logic [AM_W-1:0] mag2;
      logic [R_W-1:0]  r;
   } qent_type;

   typedef struct packed {
      logic     valid;
      qent_type ent;
   } qpush_type;

   typedef struct packed {
      logic            empty;
      logic [Q_CW-1:0] count;
   } qstat_type;

endpackage

// ===== design/gpng_sqrt.sv =====
// Pipelined digit-by-digit integer square root, one result bit per stage.
`timescale 1ns / 1ps
module gpng_sqrt (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [gpng_pkg::SQ_IN_W-1:0]  x_in,
   output logic [gpng_pkg::SQ_OUT_W-1:0] root_out
);

   logic [gpng_pkg::SQ_REM_W-1:0] rem_ff  [gpng_pkg::SQRT_STAGES];
   logic [gpng_pkg::SQ_OUT_W-1:0] root_ff [gpng_pkg::SQRT_STAGES];
   logic [gpng_pkg::SQ_IN_W-1:0]  xs_ff   [gpng_pkg::SQRT_STAGES];

   for (genvar g = 0; g < gpng_pkg::SQRT_STAGES; g++) begin : g_stage
      logic [gpng_pkg::SQ_REM_W-1:0] rem_prev, rem_sh, trial, rem_in;
      logic [gpng_pkg::SQ_OUT_W-1:0] root_prev, root_in;
      logic [gpng_pkg::SQ_IN_W-1:0]  xs_prev;

      if (g == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign xs_prev   = x_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[g-1];
         assign root_prev = root_ff[g-1];
         assign xs_prev   = xs_ff[g-1];
      end

      always_comb begin
         rem_sh = {rem_prev[gpng_pkg::SQ_REM_W-3:0],
                   xs_prev[gpng_pkg::SQ_IN_W-1:gpng_pkg::SQ_IN_W-2]};
         trial  = {root_prev, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_prev[gpng_pkg::SQ_OUT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_prev[gpng_pkg::SQ_OUT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[g]  <= rem_in;
            root_ff[g] <= root_in;
            xs_ff[g]   <= {xs_prev[gpng_pkg::SQ_IN_W-3:0], 2'b00};
         end
      end
   end

   assign root_out = root_ff[gpng_pkg::SQRT_STAGES-1];

endmodule

// ===== design/gpng_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module gpng_div (
   input  logic                       clock,
   input  logic                       adv,
   input  logic [gpng_pkg::DIV_W-1:0] dividend,
   input  logic [gpng_pkg::DQ_W-1:0]  divisor,
   output logic [gpng_pkg::DQ_W-1:0]  quotient
);

   // The upper half of the dividend is always below the divisor, so the
   // quotient fits in DQ_W bits.
   logic [gpng_pkg::DQ_W-1:0] rem_ff [gpng_pkg::DIV_STAGES];
   logic [gpng_pkg::DQ_W-1:0] lo_ff  [gpng_pkg::DIV_STAGES];
   logic [gpng_pkg::DQ_W-1:0] d_ff   [gpng_pkg::DIV_STAGES];
   logic [gpng_pkg::DQ_W-1:0] q_ff   [gpng_pkg::DIV_STAGES];

   for (genvar g = 0; g < gpng_pkg::DIV_STAGES; g++) begin : g_stage
      logic [gpng_pkg::DQ_W-1:0] rem_prev, lo_prev, d_prev, q_prev, rem_in;
      logic [gpng_pkg::DQ_W:0]   trial, diff;
      logic                      ge;

      if (g == 0) begin : g_first
         assign rem_prev = dividend[gpng_pkg::DIV_W-1:gpng_pkg::DQ_W];
         assign lo_prev  = dividend[gpng_pkg::DQ_W-1:0];
         assign d_prev   = divisor;
         assign q_prev   = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[g-1];
         assign lo_prev  = lo_ff[g-1];
         assign d_prev   = d_ff[g-1];
         assign q_prev   = q_ff[g-1];
      end

      always_comb begin
         trial  = {rem_prev, lo_prev[gpng_pkg::DQ_W-1]};
         diff   = trial - {1'b0, d_prev};
         ge     = trial >= {1'b0, d_prev};
         rem_in = ge ? diff[gpng_pkg::DQ_W-1:0] : trial[gpng_pkg::DQ_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[g] <= rem_in;
            lo_ff[g]  <= {lo_prev[gpng_pkg::DQ_W-2:0], 1'b0};
            d_ff[g]   <= d_prev;
            q_ff[g]   <= {q_prev[gpng_pkg::DQ_W-2:0], ge};
         end
      end
   end

   assign quotient = q_ff[gpng_pkg::DIV_STAGES-1];

endmodule

// ===== design/gpng_front.sv =====
// Front end: accepts requests, squares the uniforms and drops zero pairs and pairs on or outside the unit circle.
`timescale 1ns / 1ps
module gpng_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [15:0]                req_first_uniform,
   input  logic [15:0]                req_second_uniform,
   input  gpng_pkg::qstat_type        qstat,
   output gpng_pkg::qpush_type        qpush
);

   logic                         accept;
   logic [gpng_pkg::UW-1:0]      raw1, raw2, mag1_in, mag2_in;
   logic [gpng_pkg::CR_W-1:0]    credit;

   logic                         f1_vld_ff, f1_neg1_ff, f1_neg2_ff;
   logic [gpng_pkg::UW-1:0]      f1_mag1_ff, f1_mag2_ff;
   logic                         f2_vld_ff, f2_neg1_ff, f2_neg2_ff;
   logic [gpng_pkg::UW-1:0]      f2_mag1_ff, f2_mag2_ff;
   logic [gpng_pkg::SQ_W-1:0]    f2_sq1_ff, f2_sq2_ff;
   logic [gpng_pkg::RSUM_W-1:0]  rsum;
   logic                         keep;
   gpng_pkg::qpush_type          qpush_ff, qpush_in;

   // Every request in flight holds a queue slot, so the queue never overflows.
   assign credit = gpng_pkg::CR_W'(qstat.count) + gpng_pkg::CR_W'(f1_vld_ff)
                 + gpng_pkg::CR_W'(f2_vld_ff) + gpng_pkg::CR_W'(qpush_ff.valid);
   assign req_stall = credit >= gpng_pkg::CR_W'(gpng_pkg::Q_DEPTH);
   assign accept    = req_valid && !req_stall;

   assign raw1    = req_first_uniform[gpng_pkg::UW-1:0];
   assign raw2    = req_second_uniform[gpng_pkg::UW-1:0];
   assign mag1_in = raw1[gpng_pkg::UW-1] ? (~raw1 + 1'b1) : raw1;
   assign mag2_in = raw2[gpng_pkg::UW-1] ? (~raw2 + 1'b1) : raw2;

   always_comb begin
      rsum = gpng_pkg::RSUM_W'(f2_sq1_ff) + gpng_pkg::RSUM_W'(f2_sq2_ff);
      keep = (rsum != '0) && (rsum < gpng_pkg::R_ONE);
      qpush_in.valid    = f2_vld_ff && keep;
      qpush_in.ent.neg1 = f2_neg1_ff;
      qpush_in.ent.neg2 = f2_neg2_ff;
      qpush_in.ent.mag1 = f2_mag1_ff[gpng_pkg::AM_W-1:0];
      qpush_in.ent.mag2 = f2_mag2_ff[gpng_pkg::AM_W-1:0];
      qpush_in.ent.r    = rsum[gpng_pkg::R_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff      <= 1'b0;
         f2_vld_ff      <= 1'b0;
         qpush_ff.valid <= 1'b0;
      end else begin
         f1_vld_ff      <= accept;
         f2_vld_ff      <= f1_vld_ff;
         qpush_ff.valid <= qpush_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      f1_neg1_ff   <= raw1[gpng_pkg::UW-1];
      f1_neg2_ff   <= raw2[gpng_pkg::UW-1];
      f1_mag1_ff   <= mag1_in;
      f1_mag2_ff   <= mag2_in;
      f2_neg1_ff   <= f1_neg1_ff;
      f2_neg2_ff   <= f1_neg2_ff;
      f2_mag1_ff   <= f1_mag1_ff;
      f2_mag2_ff   <= f1_mag2_ff;
      f2_sq1_ff    <= gpng_pkg::SQ_W'(f1_mag1_ff) * gpng_pkg::SQ_W'(f1_mag1_ff);
      f2_sq2_ff    <= gpng_pkg::SQ_W'(f1_mag2_ff) * gpng_pkg::SQ_W'(f1_mag2_ff);
      qpush_ff.ent <= qpush_in.ent;
   end

   assign qpush = qpush_ff;

endmodule

// ===== design/gpng_queue.sv =====
// Small flip-flop queue between the front end and the back pipeline.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gpng_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  gpng_pkg::qpush_type  qpush,
   input  logic                 pop,
   output gpng_pkg::qent_type   head,
   output gpng_pkg::qstat_type  qstat
);

   gpng_pkg::qent_type          mem_ff [gpng_pkg::Q_DEPTH];
   logic [gpng_pkg::Q_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [gpng_pkg::Q_CW-1:0]   count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (qpush.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !qpush.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (qpush.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (qpush.valid) begin
         mem_ff[wr_ptr_ff] <= qpush.ent;
      end
   end

   assign head        = mem_ff[rd_ptr_ff];
   assign qstat.count = count_ff;
   assign qstat.empty = (count_ff == '0);

   `ASSERT_IMP(a_no_overflow, count_ff == gpng_pkg::Q_CW'(gpng_pkg::Q_DEPTH), !qpush.valid)
   `ASSERT_IMP(a_no_underflow, count_ff == '0, !pop)
   `ASSERT_NEXT(a_count_steady, qpush.valid == pop, $stable(count_ff))

endmodule

// ===== design/gpng_back.sv =====
// Back pipeline: logarithm, square roots, divisions, scaling and the paired result stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gpng_back (
   input  logic                          clock,
   input  logic                          reset,
   input  gpng_pkg::qstat_type           qstat,
   input  gpng_pkg::qent_type            head,
   output logic                          pop,
   input  logic signed [gpng_pkg::CFG_W-1:0] mean,
   input  logic [gpng_pkg::CFG_W-1:0]    std_dev,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gpng_pkg::OUT_W-1:0]    rsp_sample,
   output logic                          rsp_last
);

   function automatic logic [gpng_pkg::OUT_W-1:0] make_sample(
      input logic [gpng_pkg::P_W-1:0]            m,
      input logic                                neg,
      input logic signed [gpng_pkg::CFG_W-1:0]   mean_v
   );
      logic signed [gpng_pkg::SUM_W-1:0] mag_s, off_s, sum_s, res_s;
      mag_s = $signed(gpng_pkg::SUM_W'(m));
      if (neg) begin
         mag_s = -mag_s;
      end
      off_s = gpng_pkg::SUM_W'(mean_v) <<< 8;
      sum_s = mag_s + off_s;
      if (sum_s > gpng_pkg::SAT_HI) begin
         res_s = gpng_pkg::SAT_HI;
      end else if (sum_s < gpng_pkg::SAT_LO) begin
         res_s = gpng_pkg::SAT_LO;
      end else begin
         res_s = sum_s;
      end
      return res_s[gpng_pkg::OUT_W-1:0];
   endfunction

   logic                                adv;
   logic [gpng_pkg::M_LAT-1:0]          vld_ff, negd1_ff, negd2_ff;

   // Normalization of r.
   logic [gpng_pkg::INT_W-1:0]          h_in, n1_h_ff, n2_i_ff;
   logic [gpng_pkg::R_W-1:0]            n1_r_ff;
   logic [63:0]                         norm_word;
   logic [gpng_pkg::XW-1:0]             n2_x_ff;

   // Logarithm by repeated squaring.
   logic [gpng_pkg::XW-1:0]             lx_ff [gpng_pkg::LOG_ROUNDS];
   logic [gpng_pkg::FRAC_W-1:0]         lf_ff [gpng_pkg::LOG_ROUNDS];
   logic [gpng_pkg::INT_W-1:0]          li_ff [gpng_pkg::LOG_ROUNDS];
   logic [gpng_pkg::L_W-1:0]            l_ff;
   logic [gpng_pkg::TP_W-1:0]           tprod;
   logic [gpng_pkg::T_W-1:0]            t_ff;

   logic [gpng_pkg::SQ_OUT_W-1:0]       s_root, q_root;
   logic [gpng_pkg::AM_W-1:0]           magd1_ff [gpng_pkg::SQRT_STAGES];
   logic [gpng_pkg::AM_W-1:0]           magd2_ff [gpng_pkg::SQRT_STAGES];
   logic [gpng_pkg::DQ_W-1:0]           c1_q, c2_q;
   logic [gpng_pkg::DQ_W-1:0]           cd1_ff [gpng_pkg::C_DLY];
   logic [gpng_pkg::DQ_W-1:0]           cd2_ff [gpng_pkg::C_DLY];

   logic [2*gpng_pkg::DQ_W-1:0]         pr1, pr2;
   logic [gpng_pkg::P_W-1:0]            p1_ff, p2_ff, m1_ff, m2_ff;
   logic [gpng_pkg::MP_W-1:0]           mp1, mp2;

   logic                                fin_vld_ff, half_ff, half_in;
   logic [gpng_pkg::OUT_W-1:0]          fin_s1_ff, fin_s2_ff;

   // The whole pipeline moves while the result stage can take a new pair.
   assign adv = !fin_vld_ff || (!rsp_stall && half_ff);
   assign pop = adv && !qstat.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[gpng_pkg::M_LAT-2:0], pop};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         negd1_ff <= {negd1_ff[gpng_pkg::M_LAT-2:0], head.neg1};
         negd2_ff <= {negd2_ff[gpng_pkg::M_LAT-2:0], head.neg2};
      end
   end

   always_comb begin
      h_in = '0;
      for (int i = 0; i < gpng_pkg::R_W; i++) begin
         if (head.r[i]) begin
            h_in = gpng_pkg::INT_W'(i);
         end
      end
   end

   assign norm_word = 64'(n1_r_ff) << (gpng_pkg::INT_W'(63) - n1_h_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         n1_r_ff <= head.r;
         n1_h_ff <= h_in;
         n2_x_ff <= norm_word[63:64-gpng_pkg::XW];
         n2_i_ff <= gpng_pkg::INT_W'(gpng_pkg::R_W) - n1_h_ff;
      end
   end

   for (genvar g = 0; g < gpng_pkg::LOG_ROUNDS; g++) begin : g_log
      logic [gpng_pkg::XW-1:0]     x_prev;
      logic [gpng_pkg::FRAC_W-1:0] f_prev;
      logic [gpng_pkg::INT_W-1:0]  i_prev;
      logic [2*gpng_pkg::XW-1:0]   sq;
      logic                        ovf;

      if (g == 0) begin : g_first
         assign x_prev = n2_x_ff;
         assign f_prev = '0;
         assign i_prev = n2_i_ff;
      end else begin : g_next
         assign x_prev = lx_ff[g-1];
         assign f_prev = lf_ff[g-1];
         assign i_prev = li_ff[g-1];
      end

      assign sq  = (2*gpng_pkg::XW)'(x_prev) * (2*gpng_pkg::XW)'(x_prev);
      assign ovf = sq[2*gpng_pkg::XW-1];

      always_ff @(posedge clock) begin
         if (adv) begin
            lx_ff[g] <= ovf ? sq[2*gpng_pkg::XW-1:gpng_pkg::XW]
                            : sq[2*gpng_pkg::XW-2:gpng_pkg::XW-1];
            lf_ff[g] <= {f_prev[gpng_pkg::FRAC_W-2:0], ovf};
            li_ff[g] <= i_prev;
         end
      end
   end

   assign tprod = gpng_pkg::TP_W'(l_ff[gpng_pkg::L_W-1:8]) * gpng_pkg::TP_W'(gpng_pkg::LN2_Q32);

   always_ff @(posedge clock) begin
      if (adv) begin
         l_ff <= {li_ff[gpng_pkg::LOG_ROUNDS-1], gpng_pkg::FRAC_W'(0)}
               - gpng_pkg::L_W'(lf_ff[gpng_pkg::LOG_ROUNDS-1]);
         t_ff <= tprod[gpng_pkg::TP_W-1:31];
      end
   end

   gpng_sqrt u_sqrt_s (
      .clock    (clock),
      .adv      (adv),
      .x_in     (gpng_pkg::SQ_IN_W'(t_ff) << gpng_pkg::T_SHIFT),
      .root_out (s_root)
   );

   gpng_sqrt u_sqrt_q (
      .clock    (clock),
      .adv      (adv),
      .x_in     (gpng_pkg::SQ_IN_W'(head.r) << gpng_pkg::Q_SHIFT),
      .root_out (q_root)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         magd1_ff[0] <= head.mag1;
         magd2_ff[0] <= head.mag2;
         for (int i = 1; i < gpng_pkg::SQRT_STAGES; i++) begin
            magd1_ff[i] <= magd1_ff[i-1];
            magd2_ff[i] <= magd2_ff[i-1];
         end
      end
   end

   gpng_div u_div1 (
      .clock    (clock),
      .adv      (adv),
      .dividend (gpng_pkg::DIV_W'(magd1_ff[gpng_pkg::SQRT_STAGES-1]) << gpng_pkg::C_SHIFT),
      .divisor  (q_root),
      .quotient (c1_q)
   );

   gpng_div u_div2 (
      .clock    (clock),
      .adv      (adv),
      .dividend (gpng_pkg::DIV_W'(magd2_ff[gpng_pkg::SQRT_STAGES-1]) << gpng_pkg::C_SHIFT),
      .divisor  (q_root),
      .quotient (c2_q)
   );

   // The quotients wait here until the square root of the log term is ready.
   always_ff @(posedge clock) begin
      if (adv) begin
         cd1_ff[0] <= c1_q;
         cd2_ff[0] <= c2_q;
         for (int i = 1; i < gpng_pkg::C_DLY; i++) begin
            cd1_ff[i] <= cd1_ff[i-1];
            cd2_ff[i] <= cd2_ff[i-1];
         end
      end
   end

   assign pr1 = (2*gpng_pkg::DQ_W)'(cd1_ff[gpng_pkg::C_DLY-1]) * (2*gpng_pkg::DQ_W)'(s_root);
   assign pr2 = (2*gpng_pkg::DQ_W)'(cd2_ff[gpng_pkg::C_DLY-1]) * (2*gpng_pkg::DQ_W)'(s_root);
   assign mp1 = gpng_pkg::MP_W'(p1_ff) * gpng_pkg::MP_W'(std_dev);
   assign mp2 = gpng_pkg::MP_W'(p2_ff) * gpng_pkg::MP_W'(std_dev);

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff <= pr1[2*gpng_pkg::DQ_W-1:30];
         p2_ff <= pr2[2*gpng_pkg::DQ_W-1:30];
         m1_ff <= mp1[gpng_pkg::MP_W-1:gpng_pkg::CFG_W];
         m2_ff <= mp2[gpng_pkg::MP_W-1:gpng_pkg::CFG_W];
      end
   end

   // Result stage: the second uniform's sample goes out first.
   always_comb begin
      half_in = half_ff;
      if (adv) begin
         half_in = 1'b0;
      end else if (fin_vld_ff && !rsp_stall && !half_ff) begin
         half_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff <= 1'b0;
         half_ff    <= 1'b0;
      end else begin
         if (adv) begin
            fin_vld_ff <= vld_ff[gpng_pkg::M_LAT-1];
         end
         half_ff <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fin_s1_ff <= make_sample(m1_ff, negd1_ff[gpng_pkg::M_LAT-1], mean);
         fin_s2_ff <= make_sample(m2_ff, negd2_ff[gpng_pkg::M_LAT-1], mean);
      end
   end

   assign rsp_valid  = fin_vld_ff;
   assign rsp_sample = half_ff ? fin_s1_ff : fin_s2_ff;
   assign rsp_last   = half_ff;

   `ASSERT_IMP(a_half_needs_pair, half_ff, fin_vld_ff)
   `ASSERT_IMP(a_hold_on_first, fin_vld_ff && !half_ff, !adv)
   `ASSERT_NEXT(a_pop_enters_pipe, pop, vld_ff[0])

endmodule

// ===== design/gaussian_polar_noise_generator_top.sv =====
// Top level of the Marsaglia polar Gaussian noise generator.
//
//   Channel | Direction | Handshake            | Payload
//   req     | in        | req_valid/req_stall  | first_uniform, second_uniform (Q1.15)
//   rsp     | out       | rsp_valid/rsp_stall  | sample (Q16.16), last
//   csr     | in        | csr_write            | csr_index, csr_data
//
// A request passes the front end's input, square and push registers, then waits
// in an eight-entry queue. The back pipeline is 71 stages deep from queue pop to
// the result stage; its length is set by the 32 squaring rounds of the
// logarithm followed by the 32-stage square root.
// A kept request yields two samples in turn on the single result port, and while
// a pair waits there, the back pipeline takes a new request only as the second
// one goes out; rejected pairs are taken at the input like any other and
// produce nothing. Reset is synchronous and clears the valid bits, queue
// pointers and the configuration registers (mean 0, std_dev 1.0); there is no
// clearing pass. A stall on the result side freezes the back pipeline, while
// the queue keeps accepting requests until its slots are spoken for.
`timescale 1ns / 1ps
module gaussian_polar_noise_generator_top (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [15:0]                  req_first_uniform,
   input  logic signed [15:0]                  req_second_uniform,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [31:0]                  rsp_sample,
   output logic                                rsp_last,

   input  logic                                csr_write,
   input  logic [gpng_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gpng_pkg::CFG_W-1:0]          csr_data
);

   // Configuration registers. They are written only while the block is idle, so the
   // pipeline reads them directly; this binds the user, the block does not enforce it.
   logic [gpng_pkg::CFG_W-1:0] mean_ff, std_dev_ff;

   gpng_pkg::qpush_type qpush;
   gpng_pkg::qstat_type qstat;
   gpng_pkg::qent_type  q_head;
   logic                q_pop;
   logic [31:0]         sample_bits;

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff    <= '0;
         std_dev_ff <= gpng_pkg::STD_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            gpng_pkg::CSR_MEAN: begin
               mean_ff <= csr_data;
            end
            gpng_pkg::CSR_STD_DEV: begin
               std_dev_ff <= csr_data;
            end
            default: begin
               // Writes to unmapped indexes are dropped.
            end
         endcase
      end
   end

   // Front end: magnitudes, squares, and the unit-circle test.
   gpng_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_first_uniform  (req_first_uniform),
      .req_second_uniform (req_second_uniform),
      .qstat              (qstat),
      .qpush              (qpush)
   );

   // The queue lets the front end keep taking requests while results stall.
   gpng_queue u_queue (
      .clock (clock),
      .reset (reset),
      .qpush (qpush),
      .pop   (q_pop),
      .head  (q_head),
      .qstat (qstat)
   );

   // Back pipeline: computes both samples of a pair and hands them out in order.
   gpng_back u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .head       (q_head),
      .pop        (q_pop),
      .mean       ($signed(mean_ff)),
      .std_dev    (std_dev_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_sample (sample_bits),
      .rsp_last   (rsp_last)
   );

   assign rsp_sample = $signed(sample_bits);

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the polar Gaussian noise generator top level.
`timescale 1ns / 1ps
module tb;

   localparam string PASS_MSG = "gaussian_polar_noise_generator_top verification clean";
   localparam string FAIL_MSG = "gaussian_polar_noise_generator_top verification failed";

   // Register slots that are not mapped; writes to them must be dropped.
   localparam gpng_pkg::csr_index_type CSR_SPARE_LO = gpng_pkg::csr_index_type'(2'd2);
   localparam gpng_pkg::csr_index_type CSR_SPARE_HI = gpng_pkg::csr_index_type'(2'd3);

   // Cycles a request may still be in flight after the last sample came out.
   localparam int SETTLE_CYCLES = 120;

   // Holds the live register copy and the queue of samples the block owes.
   class gauss_scoreboard;
      logic signed [15:0] mean_q78;
      logic [15:0]        scale_q88;
      logic signed [31:0] owed_sample[$];
      logic               owed_last[$];
      int                 errors;

      function new();
         mean_q78  = 16'sd0;
         scale_q88 = gpng_pkg::STD_RESET;
         errors    = 0;
      endfunction

      function void set_register(gpng_pkg::csr_index_type idx, logic [15:0] value);
         case (idx)
            gpng_pkg::CSR_MEAN: begin
               mean_q78 = value;
            end
            gpng_pkg::CSR_STD_DEV: begin
               scale_q88 = value;
            end
            default: begin
            end
         endcase
      endfunction

      function longint unsigned int_sqrt(longint unsigned x);
         longint unsigned root;
         longint unsigned bitval;
         root   = 0;
         bitval = 64'd1 << 62;
         while (bitval > x) bitval >>= 2;
         while (bitval != 0) begin
            if (x >= root + bitval) begin
               x    = x - (root + bitval);
               root = (root >> 1) + bitval;
            end else begin
               root >>= 1;
            end
            bitval >>= 2;
         end
         return root;
      endfunction

      // One output sample: |v|/sqrt(r) times sqrt(-2 ln r), scaled, signed, offset, clamped.
      function logic signed [31:0] gauss_sample(longint unsigned mag, bit neg,
                                                longint unsigned root_r,
                                                longint unsigned root_t);
         longint unsigned ratio;
         longint unsigned prod;
         longint unsigned scaled;
         longint signed   value;
         ratio  = (mag << gpng_pkg::C_SHIFT) / root_r;
         prod   = (ratio * root_t) >> 30;
         scaled = (prod * longint'(scale_q88)) >> 16;
         value  = neg ? -longint'(scaled) : longint'(scaled);
         value  = value + longint'(mean_q78) * 256;
         if (value > 64'sd2147483647) value = 64'sd2147483647;
         if (value < -64'sd2147483648) value = -64'sd2147483648;
         return value[31:0];
      endfunction

      function void note_request(logic signed [15:0] v1, logic signed [15:0] v2);
         longint unsigned mag1, mag2, r, x, frac, log2_neg, ln_term, root_t, root_r;
         bit              neg1, neg2;
         int              top;
         neg1 = v1[15];
         neg2 = v2[15];
         mag1 = neg1 ? 64'd65536 - {48'd0, v1} : {48'd0, v1};
         mag2 = neg2 ? 64'd65536 - {48'd0, v2} : {48'd0, v2};
         r    = mag1 * mag1 + mag2 * mag2;
         // Zero pairs and pairs on or outside the unit circle are dropped.
         if (r == 0 || r >= (64'd1 << (2 * gpng_pkg::FW))) return;
         top = 0;
         for (int i = 0; i < 64; i++) if (r[i]) top = i;
         x    = (top >= 31) ? (r >> (top - 31)) : (r << (31 - top));
         frac = 0;
         for (int i = 0; i < 32; i++) begin
            x    = (x * x) >> 31;
            frac = frac << 1;
            if (x >= (64'd2 << 31)) begin
               x    = x >> 1;
               frac = frac | 64'd1;
            end
         end
         log2_neg = (longint'(2 * gpng_pkg::FW - top) << 32) - frac;
         ln_term  = ((log2_neg >> 8) * longint'(gpng_pkg::LN2_Q32)) >> 31;
         root_t   = int_sqrt(ln_term << gpng_pkg::T_SHIFT);
         root_r   = int_sqrt(r << gpng_pkg::Q_SHIFT);
         if (root_r == 0) root_r = 1;
         owed_sample.push_back(gauss_sample(mag2, neg2, root_r, root_t));
         owed_last.push_back(1'b0);
         owed_sample.push_back(gauss_sample(mag1, neg1, root_r, root_t));
         owed_last.push_back(1'b1);
      endfunction

      task report(string what);
         $display("ERROR @%0t: %s", $realtime, what);
         errors++;
      endtask

      task check(logic signed [31:0] sample, logic last);
         logic signed [31:0] want_sample;
         logic               want_last;
         if (owed_sample.size() == 0) begin
            report($sformatf("unexpected sample %0d last %0b", sample, last));
         end else begin
            want_sample = owed_sample.pop_front();
            want_last   = owed_last.pop_front();
            if (sample !== want_sample)
               report($sformatf("sample %0d, wanted %0d", sample, want_sample));
            if (last !== want_last)
               report($sformatf("last %0b, wanted %0b", last, want_last));
         end
      endtask

      function int pending();
         return owed_sample.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_first_uniform = '0;
   logic signed [15:0] req_second_uniform = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_sample;
   logic               rsp_last;
   logic               csr_write = 1'b0;
   logic [gpng_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [gpng_pkg::CFG_W-1:0]     csr_data = '0;

   gauss_scoreboard sb = new();

   // Cycles of forced stall on the result side; loaded by the main sequence.
   int hold_cycles = 0;
   int stall_mode = 0;
   int stall_phase = 0;

   gaussian_polar_noise_generator_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_first_uniform  (req_first_uniform),
      .req_second_uniform (req_second_uniform),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample         (rsp_sample),
      .rsp_last           (rsp_last),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #6 clock = ~clock;

   // Result side: check every accepted sample, then pick next cycle's stall.
   // The stall style is picked anew at random at regular intervals so that stalls land on every
   // phase of the pipeline, with some stretches of no stall at all.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_sample, rsp_last);
      stall_phase <= stall_phase + 1;
      if (stall_phase % 97 == 0) stall_mode <= $urandom_range(0, 3);
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall   <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 1) == 1);
            2: rsp_stall <= ($urandom_range(0, 4) != 0);
            default: rsp_stall <= (stall_phase % 5 < 2);
         endcase
      end
   end

   // Offers one request and holds it until the block takes it.
   task automatic offer_pair(logic signed [15:0] v1, logic signed [15:0] v2);
      req_valid          <= 1'b1;
      req_first_uniform  <= v1;
      req_second_uniform <= v2;
      do @(posedge clock); while (req_stall);
      sb.note_request(v1, v2);
   endtask

   // Lowers valid for a gap; a zero gap keeps the next request back to back.
   task automatic idle_sender(int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Waits until every owed sample has come and the pipeline has emptied.
   task automatic drain_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The write strobe drops again after every write.
   task automatic write_register(gpng_pkg::csr_index_type idx, logic [15:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      sb.set_register(idx, value);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Random phase: bursts of random length and random gaps. Most pairs are
   // full-range uniforms, the rest are tiny magnitudes that drive r toward
   // zero and push the samples into the tails.
   task automatic random_phase(int count, bit with_hold);
      int burst_left;
      logic signed [15:0] v1, v2;
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < count; n++) begin
         if (with_hold && n == 20) hold_cycles = 400;
         if ($urandom_range(0, 9) == 0) begin
            v1 = $signed(16'($urandom_range(0, 31)) - 16'd16);
            v2 = $signed(16'($urandom_range(0, 31)) - 16'd16);
         end else begin
            v1 = $signed(16'($urandom()));
            v2 = $signed(16'($urandom()));
         end
         offer_pair(v1, v2);
         burst_left--;
         if (burst_left == 0) begin
            idle_sender($urandom_range(0, 8));
            burst_left = $urandom_range(1, 24);
         end
      end
   endtask

   initial begin
      #(12 * 400000);
      $display(FAIL_MSG);
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pairs at reset settings: zero pair, pairs holding -1.0,
      // the largest kept magnitude, the smallest nonzero r, and both sides
      // of the unit circle edge.
      offer_pair(16'sd0, 16'sd0);
      offer_pair(-16'sd32768, 16'sd0);
      offer_pair(16'sd0, -16'sd32768);
      offer_pair(-16'sd32768, -16'sd32768);
      offer_pair(16'sd32767, 16'sd0);
      offer_pair(16'sd0, -16'sd32767);
      offer_pair(16'sd1, 16'sd0);
      offer_pair(16'sd0, -16'sd1);
      offer_pair(-16'sd1, 16'sd1);
      offer_pair(16'sd23170, 16'sd23170);
      offer_pair(16'sd23171, -16'sd23171);
      offer_pair(-16'sd32767, -16'sd1);
      offer_pair(16'sd32767, 16'sd32767);
      offer_pair(16'sd12000, -16'sd9000);
      drain_block();

      // Extreme scale and both extreme offsets; unmapped slots are written
      // too and must leave the live settings alone.
      write_register(gpng_pkg::CSR_STD_DEV, 16'hFFFF);
      write_register(gpng_pkg::CSR_MEAN, 16'h8000);
      write_register(CSR_SPARE_LO, 16'h1234);
      write_register(CSR_SPARE_HI, 16'hFFFF);
      offer_pair(16'sd1, 16'sd0);
      offer_pair(-16'sd1, -16'sd1);
      offer_pair(16'sd20000, -16'sd20000);
      random_phase(150, 1'b1);
      drain_block();

      write_register(gpng_pkg::CSR_MEAN, 16'h7FFF);
      random_phase(150, 1'b0);
      drain_block();

      write_register(gpng_pkg::CSR_STD_DEV, 16'h0000);
      write_register(gpng_pkg::CSR_MEAN, 16'h0000);
      random_phase(120, 1'b0);
      drain_block();

      for (int k = 0; k < 3; k++) begin
         write_register(gpng_pkg::CSR_MEAN, 16'($urandom()));
         write_register(gpng_pkg::CSR_STD_DEV, 16'($urandom()));
         random_phase(130, 1'b0);
         drain_block();
      end

      if (sb.errors == 0) begin
         $display(PASS_MSG);
      end else begin
         $display(FAIL_MSG);
      end
      $finish;
   end
endmodule

// ===== gaussian_polar_noise_generator_top.f =====
+incdir+design
design/gpng_pkg.sv
design/gpng_sqrt.sv
design/gpng_div.sv
design/gpng_front.sv
design/gpng_queue.sv
design/gpng_back.sv
design/gaussian_polar_noise_generator_top.sv
tb/tb.sv
